FILE: src/abslc_pkg.sv
package abslc_pkg;

  localparam int unsigned LevelW = 16;
  localparam int unsigned LuxW = 16;
  localparam int unsigned StepW = 8;
  localparam int unsigned ReqW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ScaledLuxW = 13;
  localparam int unsigned DivW = LevelW + ScaledLuxW;
  localparam int unsigned DivCntW = $clog2(DivW);
  localparam int unsigned MarginW = 11;
  localparam int unsigned RecipW = 19;
  localparam int unsigned RecipProdW = LevelW + RecipW;

  localparam logic [ReqW-1:0] REQ_TICK = 3'd0;
  localparam logic [ReqW-1:0] REQ_STEP_UP = 3'd1;
  localparam logic [ReqW-1:0] REQ_STEP_DOWN = 3'd2;
  localparam logic [ReqW-1:0] REQ_SET = 3'd3;
  localparam logic [ReqW-1:0] REQ_SYNC = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_MIN_BRIGHTNESS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_BRIGHTNESS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STEP_COUNT = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_AUTO_ENABLE = 2'd3;

  localparam logic [LevelW-1:0] MIN_BRIGHTNESS_RST = 16'd1000;
  localparam logic [LevelW-1:0] MAX_BRIGHTNESS_RST = 16'd60000;
  localparam logic [StepW-1:0] STEP_COUNT_RST = 8'd16;
  localparam logic [LuxW-1:0] BASE_LIGHT_RST = 16'd100;

  localparam logic [LuxW-1:0] LUX_FLOOR = 16'd2;
  localparam logic [LuxW-1:0] LUX_CEIL = 16'd5000;
  localparam logic [MarginW-1:0] DEADBAND_MIN = 11'd1500;
  localparam logic [MarginW-1:0] SLEW_MIN = 11'd500;

  // x / 100 as (x * 335545) >> 25, exact for x below 2^18
  localparam logic [RecipW-1:0] RECIP_100 = 19'd335545;
  localparam int unsigned RecipShift = 25;

  typedef struct packed {
    logic [ReqW-1:0]   req_type;
    logic [LuxW-1:0]   lux;
    logic [LevelW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [LevelW-1:0] brightness;
    logic              write_strobe;
  } out_t;

  typedef struct packed {
    logic [LevelW-1:0]  min_brightness;
    logic [LevelW-1:0]  max_brightness;
    logic [StepW-1:0]   step_count;
    logic               auto_enable;
    logic [MarginW-1:0] deadband;
    logic [MarginW-1:0] slew_limit;
  } cfg_t;

endpackage

FILE: src/auto_brightness_slew_controller_core.sv
// Backlight controller for one display.
// Input channel (in_valid_i / in_ready_o / in_data_i): one request per transfer,
// an ambient tick, a user step up or down, a user set or a device sync, each
// carrying the current lux. Every request gives exactly one result transfer on
// out_valid_o / out_ready_i / out_data_o: the brightness now held and a write
// strobe that is set when the display must be updated.
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
// always ready; index 0 min brightness, 1 max brightness, 2 step count,
// 3 auto enable. Write only while no request is in flight.
// Ticks (when auto is enabled) and steps pass through the restoring divider
// that serves both the ambient target and the step size; sets skip it, and
// syncs, disabled ticks and ignored requests go straight to the result.
// One request is handled at a time: input is taken only while idle.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls and a second result is ready, the
// block holds it and stops taking input until the output register frees.
// Reset: min 1000, max 60000, step count 16, auto off, level and base level 0,
// base light 100, no result pending.
module auto_brightness_slew_controller_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  abslc_pkg::in_t                 in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output abslc_pkg::out_t                out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [abslc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [abslc_pkg::CfgDataW-1:0] cfg_data_i
);
  import abslc_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_START  = 8'b0000_0010,
    ST_DIV    = 8'b0000_0100,
    ST_TICK_A = 8'b0000_1000,
    ST_TICK_B = 8'b0001_0000,
    ST_STEP   = 8'b0010_0000,
    ST_APPLY  = 8'b0100_0000,
    ST_FIN    = 8'b1000_0000
  } state_e;

  localparam int unsigned ErrW = LevelW + 2;

  cfg_t cfg;

  state_e state_d, state_q;
  logic [ReqW-1:0]   req_d, req_q;
  logic [LuxW-1:0]   lux_d, lux_q;
  logic [LevelW-1:0] cur_d, cur_q;
  logic [LevelW-1:0] base_d, base_q;
  logic [LuxW-1:0]   light_d, light_q;
  logic              strobe_d, strobe_q;
  logic              user_d, user_q;
  logic [LevelW:0]   apply_d, apply_q;
  logic signed [ErrW-1:0] err_d, err_q;
  logic              out_valid_d, out_valid_q;
  out_t              out_d, out_q;

  logic              div_start;
  logic [DivW-1:0]   div_dividend;
  logic [LevelW-1:0] div_divisor;
  logic              div_done;
  logic [DivW-1:0]   div_quo;

  logic              is_tick;
  logic [ScaledLuxW-1:0] lux_clamped;
  logic [LevelW-1:0] range0;
  logic [StepW-1:0]  steps;
  logic [DivW-1:0]   tgt_raw;
  logic [LevelW-1:0] tgt;
  logic signed [ErrW-1:0] err;
  logic signed [ErrW-1:0] db_s;
  logic signed [ErrW-1:0] lim_s;
  logic signed [ErrW-1:0] err_lim;
  logic signed [ErrW-1:0] new_lvl;
  logic [LevelW-1:0] st;
  logic [LevelW-1:0] room;
  logic [LevelW-1:0] nv;
  logic [LevelW-1:0] applied;

  function automatic logic [LevelW-1:0] limit_level(logic [DivW-1:0] v, cfg_t c);
    logic [DivW-1:0] r;
    r = (v > DivW'(c.max_brightness)) ? DivW'(c.max_brightness) : v;
    if (r < DivW'(c.min_brightness)) begin
      r = DivW'(c.min_brightness);
    end
    return r[LevelW-1:0];
  endfunction

  abslc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  abslc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign is_tick = (req_q == REQ_TICK);

  assign lux_clamped = (lux_q < LUX_FLOOR) ? ScaledLuxW'(LUX_FLOOR) :
                       (lux_q > LUX_CEIL)  ? ScaledLuxW'(LUX_CEIL)  :
                                             lux_q[ScaledLuxW-1:0];
  assign range0 = (cfg.max_brightness > cfg.min_brightness) ?
                  (cfg.max_brightness - cfg.min_brightness) : '0;
  assign steps  = (cfg.step_count == '0) ? StepW'(1) : cfg.step_count;

  assign div_start    = (state_q == ST_START);
  assign div_dividend = is_tick ? (DivW'(base_q) * DivW'(lux_clamped)) : DivW'(range0);
  assign div_divisor  = is_tick ? light_q : LevelW'(steps);

  // ambient target and deadband
  assign tgt_raw = (light_q == '0) ? DivW'(cfg.max_brightness) : div_quo;
  assign tgt     = limit_level(tgt_raw, cfg);
  assign err     = $signed(ErrW'(tgt)) - $signed(ErrW'(cur_q));
  assign db_s    = $signed(ErrW'(cfg.deadband));
  assign lim_s   = $signed(ErrW'(cfg.slew_limit));

  // slew limit
  always_comb begin
    priority if (err_q > lim_s) begin
      err_lim = lim_s;
    end else if (err_q < -lim_s) begin
      err_lim = -lim_s;
    end else begin
      err_lim = err_q;
    end
  end
  assign new_lvl = $signed(ErrW'(cur_q)) + err_lim;

  // user step
  assign st = (div_quo[LevelW-1:0] == '0) ? LevelW'(1) : div_quo[LevelW-1:0];
  always_comb begin
    room = '0;
    nv   = cur_q;
    if (req_q == REQ_STEP_UP) begin
      if (cur_q < cfg.max_brightness) begin
        room = cfg.max_brightness - cur_q;
        nv   = cur_q + ((st < room) ? st : room);
      end
    end else if (cur_q > cfg.min_brightness) begin
      room = cur_q - cfg.min_brightness;
      nv   = cur_q - ((st < room) ? st : room);
    end
  end

  assign applied = limit_level(DivW'(apply_q), cfg);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    lux_d       = lux_q;
    cur_d       = cur_q;
    base_d      = base_q;
    light_d     = light_q;
    strobe_d    = strobe_q;
    user_d      = user_q;
    apply_d     = apply_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_data_i.req_type;
          lux_d    = in_data_i.lux;
          strobe_d = 1'b0;
          user_d   = 1'b1;
          apply_d  = (LevelW+1)'(in_data_i.value);
          unique case (in_data_i.req_type)
            REQ_TICK: state_d = cfg.auto_enable ? ST_START : ST_FIN;
            REQ_STEP_UP, REQ_STEP_DOWN: state_d = ST_START;
            REQ_SET: state_d = ST_APPLY;
            REQ_SYNC: begin
              cur_d   = in_data_i.value;
              base_d  = in_data_i.value;
              light_d = in_data_i.lux;
              state_d = ST_FIN;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = is_tick ? ST_TICK_A : ST_STEP;
        end
      end
      ST_TICK_A: begin
        priority if (err > db_s) begin
          err_d   = err - db_s;
          state_d = ST_TICK_B;
        end else if (err < -db_s) begin
          err_d   = err + db_s;
          state_d = ST_TICK_B;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_TICK_B: begin
        user_d  = 1'b0;
        apply_d = (new_lvl < 0) ? '0 : new_lvl[LevelW:0];
        state_d = ST_APPLY;
      end
      ST_STEP: begin
        apply_d = (LevelW+1)'(nv);
        state_d = (nv == cur_q) ? ST_FIN : ST_APPLY;
      end
      ST_APPLY: begin
        if (applied != cur_q) begin
          cur_d    = applied;
          strobe_d = 1'b1;
          if (user_q) begin
            base_d = applied;
            if (applied != cfg.min_brightness && applied != cfg.max_brightness) begin
              light_d = lux_q;
            end
          end
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d             = 1'b1;
          out_d.brightness        = cur_q;
          out_d.write_strobe      = strobe_q;
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      base_q      <= '0;
      light_q     <= BASE_LIGHT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      base_q      <= base_d;
      light_q     <= light_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    lux_q    <= lux_d;
    strobe_q <= strobe_d;
    user_q   <= user_d;
    apply_q  <= apply_d;
    err_q    <= err_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/abslc_cfg.sv
module abslc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [abslc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [abslc_pkg::CfgDataW-1:0] cfg_data_i,
  output abslc_pkg::cfg_t                cfg_o
);
  import abslc_pkg::*;

  logic [LevelW-1:0]     min_q;
  logic [LevelW-1:0]     max_q;
  logic [StepW-1:0]      step_q;
  logic                  auto_q;
  logic [LevelW-1:0]     range;
  logic [RecipProdW-1:0] rmul_d, rmul_q;
  logic [RecipProdW+1:0] pct3;
  logic [MarginW-1:0]    pct_d, pct_q;
  logic [MarginW-1:0]    pct2_d, pct2_q;
  logic [MarginW-1:0]    db, lim;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= MIN_BRIGHTNESS_RST;
      max_q  <= MAX_BRIGHTNESS_RST;
      step_q <= STEP_COUNT_RST;
      auto_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_BRIGHTNESS: min_q  <= cfg_data_i;
        CFG_MAX_BRIGHTNESS: max_q  <= cfg_data_i;
        CFG_STEP_COUNT:     step_q <= cfg_data_i[StepW-1:0];
        CFG_AUTO_ENABLE:    auto_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // span of the brightness window, one when the window is empty
  assign range  = (max_q > min_q) ? (max_q - min_q) : LevelW'(1);
  assign rmul_d = RecipProdW'(range) * RecipProdW'(RECIP_100);

  assign pct3   = (RecipProdW+2)'(rmul_q) + ((RecipProdW+2)'(rmul_q) << 1);
  assign pct_d  = MarginW'(pct3 >> RecipShift);
  assign pct2_d = MarginW'(rmul_q >> (RecipShift - 1));

  always_ff @(posedge clk_i) begin
    rmul_q <= rmul_d;
    pct_q  <= pct_d;
    pct2_q <= pct2_d;
  end

  assign db  = (pct_q > DEADBAND_MIN) ? pct_q : DEADBAND_MIN;
  assign lim = (pct2_q > SLEW_MIN) ? pct2_q : SLEW_MIN;

  assign cfg_o.min_brightness = min_q;
  assign cfg_o.max_brightness = max_q;
  assign cfg_o.step_count     = step_q;
  assign cfg_o.auto_enable    = auto_q;
  assign cfg_o.deadband       = db;
  assign cfg_o.slew_limit     = lim;

endmodule

FILE: src/abslc_div.sv
module abslc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [abslc_pkg::DivW-1:0]   dividend_i,
  input  logic [abslc_pkg::LevelW-1:0] divisor_i,
  output logic                         done_o,
  output logic [abslc_pkg::DivW-1:0]   quotient_o
);
  import abslc_pkg::*;

  logic               busy_d, busy_q;
  logic               done_d, done_q;
  logic [DivCntW-1:0] cnt_d, cnt_q;
  logic [LevelW-1:0]  rem_d, rem_q;
  logic [LevelW-1:0]  dvs_d, dvs_q;
  logic [DivW-1:0]    quo_d, quo_q;
  logic [LevelW:0]    trial;
  logic               fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[DivW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivW - 1);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? LevelW'(trial - {1'b0, dvs_q}) : trial[LevelW-1:0];
      quo_d = {quo_q[DivW-2:0], fits};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: test/auto_brightness_slew_controller_core_tb.sv
`timescale 1ns / 100ps

module auto_brightness_slew_controller_core_tb;
  import abslc_pkg::*;

  localparam int QuietLimit = 3000;
  localparam int HoldOffCycles = 300;
  localparam int ItemsPerPhase = 150;
  localparam logic [ReqW-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [ReqW-1:0] REQ_SPARE_HI = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // predictor state and register copy
  logic [LevelW-1:0] level_now;
  logic [LevelW-1:0] level_base;
  logic [LuxW-1:0] lux_base;
  logic [LevelW-1:0] cfg_min;
  logic [LevelW-1:0] cfg_max;
  logic [StepW-1:0] cfg_steps;
  logic cfg_auto;

  out_t pending_levels[$];
  int err_count = 0;
  int quiet_cycles = 0;
  int hold_off_req = 0;
  int stall_left = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  auto_brightness_slew_controller_core DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned clamp_level(int unsigned v);
    if (v > cfg_max) v = cfg_max;
    if (v < cfg_min) v = cfg_min;
    return v;
  endfunction

  function automatic logic apply_level(int unsigned v, logic user, logic [LuxW-1:0] lux);
    int unsigned lvl;
    lvl = clamp_level(v);
    if (lvl == level_now) return 1'b0;
    level_now = lvl[LevelW-1:0];
    if (user) begin
      level_base = lvl[LevelW-1:0];
      if (lvl != cfg_min && lvl != cfg_max) lux_base = lux;
    end
    return 1'b1;
  endfunction

  function automatic out_t predict_level(in_t req);
    out_t res;
    logic strobe;
    int unsigned lux_c, tgt, span0, stp, room, nv;
    int span, db, lim, err, lvl;
    strobe = 1'b0;
    lvl = level_now;
    case (req.req_type)
      REQ_TICK: if (cfg_auto) begin
        lux_c = (req.lux < LUX_FLOOR) ? LUX_FLOOR : ((req.lux > LUX_CEIL) ? LUX_CEIL : req.lux);
        if (lux_base == '0) tgt = cfg_max;
        else tgt = (32'(level_base) * lux_c) / lux_base;
        tgt = clamp_level(tgt);
        span = (cfg_max > cfg_min) ? cfg_max - cfg_min : 1;
        db = span * 3 / 100;
        if (db < 1) db = 1;
        if (db < DEADBAND_MIN) db = DEADBAND_MIN;
        lim = span * 2 / 100;
        if (lim < SLEW_MIN) lim = SLEW_MIN;
        err = int'(tgt) - lvl;
        if (err > db) err -= db;
        else if (err < -db) err += db;
        else err = 0;
        if (err != 0) begin
          if (err > lim) err = lim;
          if (err < -lim) err = -lim;
          err += lvl;
          if (err < 0) err = 0;
          strobe = apply_level(err, 1'b0, req.lux);
        end
      end
      REQ_STEP_UP, REQ_STEP_DOWN: begin
        span0 = (cfg_max > cfg_min) ? cfg_max - cfg_min : 0;
        stp = span0 / ((cfg_steps == '0) ? 1 : cfg_steps);
        if (stp < 1) stp = 1;
        nv = level_now;
        if (req.req_type == REQ_STEP_UP) begin
          if (level_now < cfg_max) begin
            room = cfg_max - level_now;
            nv = level_now + ((stp < room) ? stp : room);
          end
        end else if (level_now > cfg_min) begin
          room = level_now - cfg_min;
          nv = level_now - ((stp < room) ? stp : room);
        end
        if (nv != level_now) strobe = apply_level(nv, 1'b1, req.lux);
      end
      REQ_SET: strobe = apply_level(req.value, 1'b1, req.lux);
      REQ_SYNC: begin
        level_now = req.value;
        level_base = req.value;
        lux_base = req.lux;
      end
      default: ;
    endcase
    res.brightness = level_now;
    res.write_strobe = strobe;
    return res;
  endfunction

  function automatic in_t rand_req();
    in_t req;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) req.req_type = REQ_TICK;
    else if (r < 57) req.req_type = REQ_STEP_UP;
    else if (r < 69) req.req_type = REQ_STEP_DOWN;
    else if (r < 81) req.req_type = REQ_SET;
    else if (r < 93) req.req_type = REQ_SYNC;
    else req.req_type = ReqW'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
    r = $urandom_range(0, 99);
    if (r < 10) req.lux = LuxW'($urandom_range(0, 8));
    else if (r < 20) req.lux = LuxW'($urandom_range(4990, 5010));
    else if (r < 35) req.lux = LuxW'($urandom());
    else req.lux = LuxW'($urandom_range(20, 3000));
    r = $urandom_range(0, 99);
    if (r < 10) req.value = cfg_min;
    else if (r < 20) req.value = cfg_max;
    else if (r < 55 || cfg_min > cfg_max) req.value = LevelW'($urandom());
    else req.value = LevelW'($urandom_range(cfg_min, cfg_max));
    return req;
  endfunction

  task automatic send_req(input logic [ReqW-1:0] kind, input logic [LuxW-1:0] lux,
                          input logic [LevelW-1:0] level);
    int gap;
    in_t req;
    req.req_type = kind;
    req.lux = lux;
    req.value = level;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    pending_levels = {pending_levels, predict_level(req)};
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_transfer(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MIN_BRIGHTNESS: cfg_min = data;
      CFG_MAX_BRIGHTNESS: cfg_max = data;
      CFG_STEP_COUNT: cfg_steps = data[StepW-1:0];
      CFG_AUTO_ENABLE: cfg_auto = data[0];
      default: ;
    endcase
  endtask

  // unused upper data bits are randomised for the narrow registers
  task automatic set_config(input logic [LevelW-1:0] mn, input logic [LevelW-1:0] mx,
                            input logic [StepW-1:0] steps, input logic auto_en);
    wait_idle();
    cfg_transfer(CFG_MIN_BRIGHTNESS, mn);
    cfg_transfer(CFG_MAX_BRIGHTNESS, mx);
    cfg_transfer(CFG_STEP_COUNT, {8'($urandom()), steps});
    cfg_transfer(CFG_AUTO_ENABLE, {15'($urandom()), auto_en});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_config();
    send_req(REQ_TICK, 16'd400, 16'd0);
    send_req(REQ_STEP_DOWN, 16'd400, 16'd0);
    send_req(REQ_STEP_UP, 16'd400, 16'd0);
    send_req(REQ_SET, 16'd0, 16'd0);
    send_req(REQ_SET, 16'hFFFF, 16'hFFFF);
    send_req(REQ_STEP_UP, 16'd10, 16'd0);
    for (int k = REQ_SPARE_LO; k <= REQ_SPARE_HI; k++) send_req(ReqW'(k), 16'hFFFF, 16'hFFFF);
    wait_idle();
  endtask

  task automatic test_special_cases();
    set_config(MIN_BRIGHTNESS_RST, MAX_BRIGHTNESS_RST, 8'd0, 1'b1);
    send_req(REQ_STEP_UP, 16'd200, 16'd0);
    send_req(REQ_STEP_DOWN, 16'd200, 16'd0);
    send_req(REQ_SET, 16'd300, 16'd30000);
    send_req(REQ_TICK, 16'd0, 16'd0);
    send_req(REQ_TICK, 16'hFFFF, 16'd0);
    send_req(REQ_TICK, 16'd5000, 16'd0);
    send_req(REQ_SYNC, 16'd0, 16'd0);
    send_req(REQ_TICK, 16'd1, 16'd0);
    send_req(REQ_SYNC, 16'hFFFF, 16'hFFFF);
    send_req(REQ_TICK, 16'd2, 16'd0);
    // min above max
    set_config(16'hFFFF, 16'd0, 8'd255, 1'b1);
    send_req(REQ_SET, 16'd50, 16'd123);
    send_req(REQ_STEP_UP, 16'd50, 16'd0);
    send_req(REQ_STEP_DOWN, 16'd50, 16'd0);
    send_req(REQ_TICK, 16'd100, 16'd0);
    set_config(16'd0, 16'hFFFF, 8'd255, 1'b0);
    send_req(REQ_SET, 16'd7, 16'd0);
    send_req(REQ_STEP_DOWN, 16'd7, 16'd0);
    send_req(REQ_SET, 16'd7, 16'hFFFF);
    send_req(REQ_STEP_UP, 16'd7, 16'd0);
    send_req(REQ_STEP_DOWN, 16'd1234, 16'd0);
    send_req(REQ_TICK, 16'd1234, 16'd0);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    in_t req;
    set_config(MIN_BRIGHTNESS_RST, MAX_BRIGHTNESS_RST, STEP_COUNT_RST, 1'b1);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    hold_off_req = HoldOffCycles;
    repeat (12) begin
      req = rand_req();
      send_req(req.req_type, req.lux, req.value);
    end
    wait_idle();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_random_mix();
    in_t req;
    int unsigned mn;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(MIN_BRIGHTNESS_RST, MAX_BRIGHTNESS_RST, STEP_COUNT_RST, 1'b1);
        1: set_config(16'd0, 16'hFFFF, 8'd255, 1'b1);
        2: set_config(16'd0, 16'hFFFF, 8'd1, 1'b1);
        3: set_config(16'hFFFF, 16'd0, 8'd0, 1'b1);
        4: set_config(16'd30000, 16'd30000, 8'd3, 1'b1);
        5: set_config(LevelW'($urandom()), LevelW'($urandom()), StepW'($urandom()),
                      1'($urandom()));
        6: set_config(MIN_BRIGHTNESS_RST, MAX_BRIGHTNESS_RST, STEP_COUNT_RST, 1'b0);
        default: begin
          mn = $urandom_range(0, 30000);
          set_config(LevelW'(mn), LevelW'($urandom_range(mn, 65535)),
                     StepW'($urandom_range(1, 255)), 1'b1);
        end
      endcase
      gaps_on = (ph != 2 && ph != 6);
      stalls_on = (ph != 2 && ph != 5);
      repeat (ItemsPerPhase) begin
        req = rand_req();
        send_req(req.req_type, req.lux, req.value);
      end
    end
    wait_idle();
  endtask

  // result sink with random stalls and requested hold-offs
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (hold_off_req > 0) begin
        stall_left = hold_off_req;
        hold_off_req = 0;
      end else if (stall_left == 0 && stalls_on && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_levels.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result transfer, brightness %0d strobe %0b", $time,
                   out_data_o.brightness, out_data_o.write_strobe);
        end else begin
          want = pending_levels.pop_front();
          if (out_data_o.brightness !== want.brightness) begin
            err_count++;
            $display("%0t: brightness expected %0d actual %0d", $time,
                     want.brightness, out_data_o.brightness);
          end
          if (out_data_o.write_strobe !== want.write_strobe) begin
            err_count++;
            $display("%0t: write_strobe expected %0b actual %0b", $time,
                     want.write_strobe, out_data_o.write_strobe);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_MIN_BRIGHTNESS;
    cfg_data_i = '0;
    cfg_min = MIN_BRIGHTNESS_RST;
    cfg_max = MAX_BRIGHTNESS_RST;
    cfg_steps = STEP_COUNT_RST;
    cfg_auto = 1'b0;
    level_now = '0;
    level_base = '0;
    lux_base = BASE_LIGHT_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_special_cases();
    test_output_backpressure();
    test_random_mix();
    wait_idle();
    repeat (60) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
